// ----- hdl/fpa_pkg.sv -----
// Package with the command codes and default sizes of the fixed-point ALU.
package fpa_pkg;

	localparam int unsigned FRAC_BITS_DEF = 8;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_LT       = 4'd4,
		CMD_GT       = 4'd5,
		CMD_LE       = 4'd6,
		CMD_GE       = 4'd7,
		CMD_EQ       = 4'd8,
		CMD_NE       = 4'd9,
		CMD_MIN      = 4'd10,
		CMD_MAX      = 4'd11,
		CMD_INC      = 4'd12,
		CMD_DEC      = 4'd13,
		CMD_FROM_INT = 4'd14,
		CMD_TO_INT   = 4'd15
	} cmd_t;

endpackage

// ----- hdl/fixed_point_alu_top.sv -----
// Pipelined signed fixed-point ALU with a pipelined restoring divider.
//
// This ALU accepts one item per clock cycle unless stalled and returns exactly one result
// item per input item, in order. Every item, whatever its command, travels the same
// pipeline of FRAC_BITS + 36 register stages (44 with the default FRAC_BITS of
// 8): an input register, an operand stage holding the 32x32 signed product and
// the divider setup, a stage that rescales the product, one restoring-divider
// stage per quotient bit (32 + FRAC_BITS of them), and an output register. The
// divider sets that depth: it produces one quotient bit per stage. The whole
// pipeline advances together whenever the output register is empty or its item
// is being taken, so in_ready follows out_ready combinationally, and a stall
// freezes all stages without losing or repeating an item. Multiply shifts the
// 64-bit product right arithmetically by FRAC_BITS; divide scales the dividend
// by 2^FRAC_BITS and truncates toward zero. A zero divisor sets divide_by_zero
// and gives a zero value. Comparison commands report on compare_true with a
// zero value. All arithmetic wraps to 32 bits.
module fixed_point_alu_top
	import fpa_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [3:0]               command,
	input  logic signed [DATA_W-1:0] operand_a,
	input  logic signed [DATA_W-1:0] operand_b,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] value,
	output logic                     compare_true,
	output logic                     divide_by_zero
);

	// Width of the scaled dividend and therefore the number of divider steps.
	localparam int unsigned QW = DATA_W + FRAC_BITS;

	logic en;

	// Stage 1: input register.
	logic                     vld_s1;
	cmd_t                     cmd_s1;
	logic signed [DATA_W-1:0] a_s1;
	logic signed [DATA_W-1:0] b_s1;

	// Stage 2: product, simple results and divider operands.
	logic                       vld_s2;
	logic                       ismul_s2;
	logic                       isdiv_s2;
	logic signed [2*DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0]          val_s2;
	logic                       cmp_s2;
	logic [QW-1:0]              dvd_s2;
	logic [DATA_W-1:0]          dsr_s2;
	logic                       neg_s2;
	logic                       dz_s2;

	// Divider chain; entry 0 is the stage after stage 2, entry k+1 follows step k.
	logic              vld_s   [0:QW];
	logic              isdiv_s [0:QW];
	logic [DATA_W-1:0] val_s   [0:QW];
	logic              cmp_s   [0:QW];
	logic [QW-1:0]     dvd_s   [0:QW];
	logic [DATA_W-1:0] rem_s   [0:QW];
	logic [DATA_W-1:0] dsr_s   [0:QW];
	logic              neg_s   [0:QW];
	logic              dz_s    [0:QW];

	// Output register.
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     cmp_q;
	logic                     dz_q;

	// All stages move together unless a finished item waits at the output.
	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_t'(command);
			a_s1   <= operand_a;
			b_s1   <= operand_b;
		end
	end

	// Stage 2 logic: everything except multiply and divide finishes here.
	logic              lt_c;
	logic              gt_c;
	logic              eq_c;
	logic [DATA_W-1:0] val_c;
	logic              cmp_c;
	logic [DATA_W-1:0] mag_a_c;
	logic [DATA_W-1:0] mag_b_c;

	always_comb begin
		lt_c    = a_s1 < b_s1;
		gt_c    = a_s1 > b_s1;
		eq_c    = a_s1 == b_s1;
		val_c   = '0;
		cmp_c   = 1'b0;
		mag_a_c = a_s1[DATA_W-1] ? DATA_W'(-a_s1) : DATA_W'(a_s1);
		mag_b_c = b_s1[DATA_W-1] ? DATA_W'(-b_s1) : DATA_W'(b_s1);
		case (cmd_s1)
			CMD_ADD:      val_c = DATA_W'(a_s1 + b_s1);
			CMD_SUB:      val_c = DATA_W'(a_s1 - b_s1);
			CMD_MUL:      val_c = '0;
			CMD_DIV:      val_c = '0;
			CMD_LT:       cmp_c = lt_c;
			CMD_GT:       cmp_c = gt_c;
			CMD_LE:       cmp_c = !gt_c;
			CMD_GE:       cmp_c = !lt_c;
			CMD_EQ:       cmp_c = eq_c;
			CMD_NE:       cmp_c = !eq_c;
			CMD_MIN:      val_c = lt_c ? a_s1 : b_s1;
			CMD_MAX:      val_c = gt_c ? a_s1 : b_s1;
			CMD_INC:      val_c = DATA_W'(a_s1 + DATA_W'(1));
			CMD_DEC:      val_c = DATA_W'(a_s1 - DATA_W'(1));
			CMD_FROM_INT: val_c = DATA_W'(a_s1 << FRAC_BITS);
			CMD_TO_INT:   val_c = DATA_W'(a_s1 >>> FRAC_BITS);
			default:      val_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ismul_s2 <= cmd_s1 == CMD_MUL;
			isdiv_s2 <= cmd_s1 == CMD_DIV;
			prod_s2  <= a_s1 * b_s1;
			val_s2   <= val_c;
			cmp_s2   <= cmp_c;
			dvd_s2   <= {mag_a_c, FRAC_BITS'(0)};
			dsr_s2   <= mag_b_c;
			neg_s2   <= a_s1[DATA_W-1] ^ b_s1[DATA_W-1];
			dz_s2    <= b_s1 == '0;
		end
	end

	// Entry 0: rescale the product and start the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			isdiv_s[0] <= isdiv_s2;
			val_s[0]   <= ismul_s2 ? DATA_W'(prod_s2 >>> FRAC_BITS) : val_s2;
			cmp_s[0]   <= cmp_s2;
			dvd_s[0]   <= dvd_s2;
			rem_s[0]   <= '0;
			dsr_s[0]   <= dsr_s2;
			neg_s[0]   <= neg_s2;
			dz_s[0]    <= dz_s2;
		end
	end

	// One quotient bit per stage. The remainder stays below the divisor, so
	// 32 bits hold it and the shifted trial value needs 33.
	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [DATA_W:0] trial;
		logic            ge;
		logic [DATA_W:0] diff;

		assign trial = {rem_s[k], dvd_s[k][QW-1]};
		assign ge    = trial >= {1'b0, dsr_s[k]};
		assign diff  = trial - {1'b0, dsr_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				isdiv_s[k+1] <= isdiv_s[k];
				val_s[k+1]   <= val_s[k];
				cmp_s[k+1]   <= cmp_s[k];
				dvd_s[k+1]   <= {dvd_s[k][QW-2:0], ge};
				rem_s[k+1]   <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
				dsr_s[k+1]   <= dsr_s[k];
				neg_s[k+1]   <= neg_s[k];
				dz_s[k+1]    <= dz_s[k];
			end
		end
	end

	// Output stage: sign the quotient and merge with the other results.
	logic [DATA_W-1:0] quo_c;

	assign quo_c = neg_s[QW] ? DATA_W'(-dvd_s[QW][DATA_W-1:0]) : dvd_s[QW][DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (isdiv_s[QW]) begin
				value_q <= dz_s[QW] ? '0 : quo_c;
				dz_q    <= dz_s[QW];
			end else begin
				value_q <= val_s[QW];
				dz_q    <= 1'b0;
			end
			cmp_q <= cmp_s[QW];
		end
	end

	assign out_valid      = out_valid_q;
	assign value          = value_q;
	assign compare_true   = cmp_q;
	assign divide_by_zero = dz_q;

	// A division by zero always reports a zero value.
	a_dz_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> value == '0)
		else $error("divide_by_zero with nonzero value");

	// A comparison outcome comes with a zero value.
	a_cmp_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> value == '0)
		else $error("compare_true with nonzero value");

	// No item is both a comparison and a division.
	a_flags_excl : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(compare_true && divide_by_zero))
		else $error("compare_true and divide_by_zero together");

	// The pipeline only stalls while the output holds an untaken item.
	a_ready : assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready out of step with output stall");

endmodule
